@@ design/atrlc_pkg.sv @@
// Shared types, codes and match tables of the AT response line classifier.
`default_nettype none
package atrlc_pkg;

	localparam int MAX_LINE_LEN = 128;
	localparam int COUNT_W = $clog2(MAX_LINE_LEN);
	localparam logic [COUNT_W-1:0] CHAR_LIMIT = COUNT_W'(MAX_LINE_LEN - 1);

	localparam int TICKS_W = 16;
	localparam int RETRY_W = 4;
	localparam int LEN_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd1;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_RETRY = 1'b1;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_CARET = 8'h5E;

	localparam int CAND_OK = 0;
	localparam int CAND_ERR = 1;
	localparam int CAND_CME = 2;
	localparam int CAND_CMS = 3;

	localparam logic [COUNT_W-1:0] LEN_OK = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] LEN_ERR = COUNT_W'(5);
	localparam logic [COUNT_W-1:0] LEN_PREFIX = COUNT_W'(11);

	typedef enum logic [2:0] {
		EV_INFO = 3'd0,
		EV_URC = 3'd1,
		EV_OK = 3'd2,
		EV_ERROR = 3'd3,
		EV_CME = 3'd4,
		EV_CMS = 3'd5,
		EV_TIMEOUT = 3'd6,
		EV_OVERFLOW = 3'd7
	} event_t;

	typedef struct packed {
		logic busy;
		logic [TICKS_W-1:0] ticks_left;
		logic [RETRY_W-1:0] attempts_used;
		logic [COUNT_W-1:0] char_count;
		logic [3:0] cand;
		logic urc_start;
	} state_t;

	typedef struct packed {
		event_t event_code;
		logic resend;
		logic done_res;
		logic [LEN_W-1:0] line_length;
		logic [RETRY_W-1:0] attempt_number;
	} result_t;

	function automatic logic [7:0] ok_char(input logic pos);
		return pos ? 8'h4B : 8'h4F;
	endfunction

	function automatic logic [7:0] error_char(input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (pos)
			3'd0: c = 8'h45;
			3'd1: c = 8'h52;
			3'd2: c = 8'h52;
			3'd3: c = 8'h4F;
			3'd4: c = 8'h52;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "+CM? ERROR:" with the fourth letter supplied
	function automatic logic [7:0] prefix_char(input logic [3:0] pos, input logic [7:0] letter);
		logic [7:0] c;
		c = 8'h00;
		unique case (pos)
			4'd0: c = 8'h2B;
			4'd1: c = 8'h43;
			4'd2: c = 8'h4D;
			4'd3: c = letter;
			4'd4: c = 8'h20;
			4'd5: c = 8'h45;
			4'd6: c = 8'h52;
			4'd7: c = 8'h52;
			4'd8: c = 8'h4F;
			4'd9: c = 8'h52;
			4'd10: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ design/atrlc_match.sv @@
// Narrows the set of final-response candidates by one line character.
`default_nettype none
module atrlc_match (
	input  wire logic [atrlc_pkg::COUNT_W-1:0] pos,
	input  wire logic [7:0]                    rx_char,
	input  wire logic [3:0]                    cand_in,
	output logic [3:0]                         cand_out
);

	logic ok_hit;
	logic err_hit;
	logic short_pos;
	logic cme_miss;
	logic cms_miss;

	always_comb begin
		ok_hit = (pos < atrlc_pkg::COUNT_W'(2)) && (atrlc_pkg::ok_char(pos[0]) == rx_char);
		err_hit = (pos < atrlc_pkg::COUNT_W'(5)) && (atrlc_pkg::error_char(pos[2:0]) == rx_char);
		short_pos = pos < atrlc_pkg::LEN_PREFIX;
		cme_miss = short_pos && (atrlc_pkg::prefix_char(pos[3:0], 8'h45) != rx_char);
		cms_miss = short_pos && (atrlc_pkg::prefix_char(pos[3:0], 8'h53) != rx_char);
		cand_out = cand_in;
		if (!ok_hit) cand_out[atrlc_pkg::CAND_OK] = 1'b0;
		if (!err_hit) cand_out[atrlc_pkg::CAND_ERR] = 1'b0;
		if (cme_miss) cand_out[atrlc_pkg::CAND_CME] = 1'b0;
		if (cms_miss) cand_out[atrlc_pkg::CAND_CMS] = 1'b0;
	end

endmodule
`default_nettype wire

@@ design/atrlc_step.sv @@
// Next state and result word for one command of the classifier.
`default_nettype none
module atrlc_step (
	input  wire atrlc_pkg::state_t               cur,
	input  wire logic [1:0]                      command,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic [atrlc_pkg::TICKS_W-1:0]   timeout_ticks,
	input  wire logic [atrlc_pkg::RETRY_W-1:0]   retry_limit,
	output atrlc_pkg::state_t                    nxt,
	output logic                                 res_valid,
	output atrlc_pkg::result_t                   res
);

	logic [3:0] cand_narrow;
	logic fail_req;
	atrlc_pkg::event_t fail_code;
	logic [atrlc_pkg::LEN_W-1:0] fail_len;
	logic [atrlc_pkg::COUNT_W-1:0] count_inc;

	atrlc_match u_match (
		.pos      (cur.char_count),
		.rx_char  (rx_byte),
		.cand_in  (cur.cand),
		.cand_out (cand_narrow)
	);

	assign count_inc = cur.char_count + atrlc_pkg::COUNT_W'(1);

	always_comb begin
		nxt = cur;
		res_valid = 1'b0;
		res.event_code = atrlc_pkg::EV_INFO;
		res.resend = 1'b0;
		res.done_res = 1'b0;
		res.line_length = atrlc_pkg::LEN_W'(cur.char_count);
		res.attempt_number = cur.attempts_used;
		fail_req = 1'b0;
		fail_code = atrlc_pkg::EV_TIMEOUT;
		fail_len = '0;

		unique case (command)
			atrlc_pkg::CMD_START: begin
				nxt.busy = 1'b1;
				nxt.attempts_used = '0;
				nxt.ticks_left = timeout_ticks;
				nxt.char_count = '0;
				nxt.cand = '1;
				nxt.urc_start = 1'b0;
			end
			atrlc_pkg::CMD_TICK: begin
				if (cur.busy) begin
					if (cur.ticks_left <= atrlc_pkg::TICKS_W'(1)) begin
						nxt.ticks_left = '0;
						fail_req = 1'b1;
						fail_code = atrlc_pkg::EV_TIMEOUT;
						fail_len = '0;
					end else begin
						nxt.ticks_left = cur.ticks_left - atrlc_pkg::TICKS_W'(1);
					end
				end
			end
			atrlc_pkg::CMD_BYTE: begin
				if (cur.busy && rx_byte != atrlc_pkg::CH_CR) begin
					if (rx_byte == atrlc_pkg::CH_LF) begin
						if (cur.char_count != '0) begin
							nxt.char_count = '0;
							nxt.cand = '1;
							nxt.urc_start = 1'b0;
							fail_len = atrlc_pkg::LEN_W'(cur.char_count);
							priority if (cur.cand[atrlc_pkg::CAND_OK]
									&& cur.char_count == atrlc_pkg::LEN_OK) begin
								nxt.busy = 1'b0;
								nxt.ticks_left = '0;
								res_valid = 1'b1;
								res.event_code = atrlc_pkg::EV_OK;
								res.done_res = 1'b1;
							end else if (cur.cand[atrlc_pkg::CAND_ERR]
									&& cur.char_count == atrlc_pkg::LEN_ERR) begin
								fail_req = 1'b1;
								fail_code = atrlc_pkg::EV_ERROR;
							end else if (cur.cand[atrlc_pkg::CAND_CME]
									&& cur.char_count >= atrlc_pkg::LEN_PREFIX) begin
								fail_req = 1'b1;
								fail_code = atrlc_pkg::EV_CME;
							end else if (cur.cand[atrlc_pkg::CAND_CMS]
									&& cur.char_count >= atrlc_pkg::LEN_PREFIX) begin
								fail_req = 1'b1;
								fail_code = atrlc_pkg::EV_CMS;
							end else begin
								res_valid = 1'b1;
								res.event_code = cur.urc_start ? atrlc_pkg::EV_URC
									: atrlc_pkg::EV_INFO;
							end
						end
					end else begin
						if (cur.char_count == '0) begin
							nxt.urc_start = (rx_byte == atrlc_pkg::CH_PLUS)
								|| (rx_byte == atrlc_pkg::CH_CARET);
						end
						nxt.cand = cand_narrow;
						nxt.char_count = count_inc;
						if (count_inc >= atrlc_pkg::CHAR_LIMIT) begin
							fail_req = 1'b1;
							fail_code = atrlc_pkg::EV_OVERFLOW;
							fail_len = atrlc_pkg::LEN_W'(count_inc);
						end
					end
				end
			end
			default: ;
		endcase

		if (fail_req) begin
			res_valid = 1'b1;
			res.event_code = fail_code;
			res.line_length = fail_len;
			nxt.char_count = '0;
			nxt.cand = '1;
			nxt.urc_start = 1'b0;
			if (cur.attempts_used < retry_limit) begin
				nxt.attempts_used = cur.attempts_used + atrlc_pkg::RETRY_W'(1);
				nxt.ticks_left = timeout_ticks;
				res.resend = 1'b1;
			end else begin
				nxt.busy = 1'b0;
				nxt.ticks_left = '0;
				res.done_res = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/at_response_line_classifier_unit.sv @@
// Top level of the AT response line classifier: handshakes, registers and checks.
//
// Takes words (start, received byte or millisecond tick) and returns at most one event word
// for each: the word is captured in an input register, the line state and the event are
// computed in one pass of short logic and land in the state and result registers. A stalled
// result holds the input side only while the input register is also occupied, so throughput
// is one word per clock while results are not stalled. The user must write the configuration
// registers only while idle; the block itself does not enforce it.
`default_nettype none
module at_response_line_classifier_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          command,
	input  wire logic [7:0]                          rx_byte,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [2:0]                               event_code,
	output logic                                     resend,
	output logic                                     done_res,
	output logic [atrlc_pkg::LEN_W-1:0]              line_length,
	output logic [atrlc_pkg::RETRY_W-1:0]            attempt_number,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic                                cfg_index,
	input  wire logic [atrlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic valid_s1;
	logic [1:0] command_s1;
	logic [7:0] rx_byte_s1;
	logic [atrlc_pkg::TICKS_W-1:0] timeout_q;
	logic [atrlc_pkg::RETRY_W-1:0] retry_q;
	atrlc_pkg::state_t state_q;
	atrlc_pkg::state_t state_nxt;
	logic res_valid;
	atrlc_pkg::result_t res;
	atrlc_pkg::result_t out_q;
	logic out_valid_q;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= atrlc_pkg::TIMEOUT_RESET;
			retry_q <= atrlc_pkg::RETRY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				atrlc_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				atrlc_pkg::CFG_RETRY: retry_q <= cfg_data[atrlc_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
		end
	end

	atrlc_step u_step (
		.cur           (state_q),
		.command       (command_s1),
		.rx_byte       (rx_byte_s1),
		.timeout_ticks (timeout_q),
		.retry_limit   (retry_q),
		.nxt           (state_nxt),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.busy <= 1'b0;
			state_q.ticks_left <= '0;
			state_q.attempts_used <= '0;
			state_q.char_count <= '0;
			state_q.cand <= '1;
			state_q.urc_start <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (valid_s1) state_q <= state_nxt;
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign event_code = out_q.event_code;
	assign resend = out_q.resend;
	assign done_res = out_q.done_res;
	assign line_length = out_q.line_length;
	assign attempt_number = out_q.attempt_number;

`ifndef SYNTH
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.busy |-> (state_q.ticks_left == '0 && state_q.char_count == '0))
		else $error("idle classifier holds attempt state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.char_count < atrlc_pkg::CHAR_LIMIT)
		else $error("line count reached store limit");

	a_resend_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.resend && out_q.done_res))
		else $error("event both retries and finishes");

	a_retry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.resend) |-> (state_q.attempts_used != '0))
		else $error("resend without attempt advance");
`endif

endmodule
`default_nettype wire
